[sv/assert_macros.svh]
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/lgcb_pkg.sv]
// shared types and constants of the gap bisector
package lgcb_pkg;

    // opcodes of an input request
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_BISECT = 2'd2;

    // field widths
    localparam int CH_PORT_W = 9;
    localparam int RND_W     = 15;
    localparam int DIV_CNT_W = 4;

    // gap thresholds
    localparam int GAP_MIN  = 1;
    localparam int GAP_WIDE = 4;

    typedef enum logic [3:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_CLR,
        ST_MARK,
        ST_MARK_LO,
        ST_MARK_HI,
        ST_SCAN,
        ST_SCAN_END,
        ST_EVAL,
        ST_DIV,
        ST_PICK,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ZERO,
        WR_MARK,
        WR_LO,
        WR_HI,
        WR_PICK
    } t_wr_sel;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    clr_step;
        t_wr_sel wr_sel;
        logic    scan_init;
        logic    scan_rd;
        logic    div_init;
        logic    div_step;
        logic    out_load;
        logic    res_found;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_ok;
        logic scan_last;
        logic gap_found;
        logic gap_wide;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[sv/lgcb_ctrl.sv]
// sequencing state machine of the gap bisector
module lgcb_ctrl
    import lgcb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_hit, n_hit;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // state and pick flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RST_CLR;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        o_cmd   = '0;
        o_cmd.wr_sel = WR_NONE;
        case (r_state)
            ST_RST_CLR: begin
                o_cmd.wr_sel   = WR_ZERO;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_hit      = 1'b0;
                    case (i_opcode)
                        OP_CLEAR:  n_state = ST_CLR;
                        OP_MARK:   n_state = ST_MARK;
                        OP_BISECT: n_state = ST_MARK_LO;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLR: begin
                o_cmd.wr_sel   = WR_ZERO;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_DONE;
            end
            ST_MARK: begin
                o_cmd.wr_sel = WR_MARK;
                n_state      = ST_DONE;
            end
            ST_MARK_LO: begin
                o_cmd.wr_sel = WR_LO;
                n_state      = ST_MARK_HI;
            end
            ST_MARK_HI: begin
                o_cmd.wr_sel    = WR_HI;
                o_cmd.scan_init = 1'b1;
                n_state         = i_sts.scan_ok ? ST_SCAN : ST_EVAL;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                // last map bit is folded in this cycle
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!i_sts.gap_found) begin
                    n_state = ST_DONE;
                end else if (i_sts.gap_wide) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_PICK;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_PICK;
            end
            ST_PICK: begin
                o_cmd.wr_sel = WR_PICK;
                n_hit        = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.res_found = r_hit;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[sv/lgcb_dpath.sv]
// probe map memory, gap scan, remainder unit and result register
`include "assert_macros.svh"

module lgcb_dpath
    import lgcb_pkg::*;
#(
    parameter int NUM_CHANNELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [CH_PORT_W-1:0] i_mark_channel,
    input  logic [CH_PORT_W-1:0] i_lower_bound,
    input  logic [CH_PORT_W-1:0] i_upper_bound,
    input  logic [RND_W-1:0]     i_random_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic [CH_PORT_W-1:0] o_picked_channel
);

    localparam int CW = $clog2(NUM_CHANNELS + 1);
    localparam int XW = (CW > CH_PORT_W) ? CW : CH_PORT_W;
    localparam logic [XW-1:0] MAX_X = XW'(NUM_CHANNELS);
    localparam logic [CW-1:0] MAX_C = CW'(NUM_CHANNELS);

    // probe map
    logic mem [0:NUM_CHANNELS];

    logic [CW-1:0]        r_addr;
    logic [CW-1:0]        r_mark, r_lo, r_hi;
    logic                 r_mark_ok;
    logic [RND_W-1:0]     r_rnd;
    logic                 r_rd_vld, r_rd_data;
    logic [CW-1:0]        r_rd_addr;
    logic [CW-1:0]        r_prev, r_best, r_start, r_stop;
    logic [CW-1:0]        r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_div_act;
    logic [CW-1:0]        r_pick;
    logic                 r_out_vld;
    logic                 r_out_found;
    logic [CH_PORT_W-1:0] r_out_pick;

    logic [XW-1:0] mark_x, lo_x, hi_x;
    logic          we, wdata;
    logic [CW-1:0] waddr;
    logic [CW-1:0] gap;
    logic [CW-1:0] half, quart;
    logic [CW:0]   div_t;
    logic [CW+1:0] wide_sum;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] pick_c;

    // input widening; the bounds saturate when they are latched
    assign mark_x = XW'(i_mark_channel);
    assign lo_x   = XW'(i_lower_bound);
    assign hi_x   = XW'(i_upper_bound);

    // write port select
    always_comb begin
        we    = 1'b0;
        wdata = 1'b1;
        waddr = r_addr;
        case (i_cmd.wr_sel)
            WR_ZERO: begin
                we    = 1'b1;
                wdata = 1'b0;
            end
            WR_MARK: begin
                we    = r_mark_ok;
                waddr = r_mark;
            end
            WR_LO: begin
                we    = 1'b1;
                waddr = r_lo;
            end
            WR_HI: begin
                we    = 1'b1;
                waddr = r_hi;
            end
            WR_PICK: begin
                we    = 1'b1;
                waddr = pick_c;
            end
            default: we = 1'b0;
        endcase
    end

    // map memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd_data <= mem[r_addr];
        r_rd_addr <= r_addr;
    end

    // address counter and request latches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.scan_init) begin
            r_addr <= r_lo + CW'(1);
        end else if (i_cmd.clr_step || i_cmd.scan_rd) begin
            r_addr <= r_addr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mark_ok <= (mark_x <= MAX_X);
            r_mark    <= mark_x[CW-1:0];
            r_lo      <= (lo_x > MAX_X) ? MAX_C : lo_x[CW-1:0];
            r_hi      <= (hi_x > MAX_X) ? MAX_C : hi_x[CW-1:0];
        end
    end

    // gap scan over returned map bits
    assign gap = r_rd_addr - r_prev - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_prev  <= r_lo;
            r_best  <= '0;
            r_start <= r_lo;
            r_stop  <= r_hi;
        end else if (r_rd_vld && r_rd_data) begin
            if (gap > r_best) begin
                r_best  <= gap;
                r_start <= r_prev;
                r_stop  <= r_rd_addr;
            end
            r_prev <= r_rd_addr;
        end
    end

    // restoring remainder, one random bit per cycle
    assign half  = r_best >> 1;
    assign quart = half >> 1;
    assign div_t = {r_rem, r_rnd[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_act <= 1'b0;
        end else if (i_cmd.div_init) begin
            r_div_act <= 1'b1;
        end else if (i_cmd.div_step && o_sts.div_last) begin
            r_div_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rnd <= i_random_value;
        end else if (i_cmd.div_step) begin
            r_rnd <= r_rnd << 1;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= (div_t >= (CW+1)'(half)) ? CW'(div_t - (CW+1)'(half)) : CW'(div_t);
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    // pick position with saturation
    assign wide_sum = (CW+2)'(r_start) + (CW+2)'(r_rem) + (CW+2)'(quart);
    assign mid_sum  = ((CW+1)'(r_start) + (CW+1)'(r_stop)) >> 1;

    always_comb begin
        if (r_best > CW'(GAP_WIDE)) begin
            pick_c = (wide_sum > (CW+2)'(NUM_CHANNELS)) ? MAX_C : wide_sum[CW-1:0];
        end else begin
            pick_c = (mid_sum > (CW+1)'(NUM_CHANNELS)) ? MAX_C : mid_sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sel == WR_PICK) r_pick <= pick_c;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= i_cmd.res_found;
            r_out_pick  <= i_cmd.res_found ? CH_PORT_W'(r_pick) : '0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_found          = r_out_found;
    assign o_picked_channel = r_out_pick;

    // status back to the controller
    assign o_sts.clr_last  = (r_addr == MAX_C);
    assign o_sts.scan_ok   = (r_lo < r_hi);
    assign o_sts.scan_last = (r_addr == r_hi);
    assign o_sts.gap_found = (r_best > CW'(GAP_MIN));
    assign o_sts.gap_wide  = (r_best > CW'(GAP_WIDE));
    assign o_sts.div_last  = (r_cnt == DIV_CNT_W'(RND_W - 1));
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

    // checks
    `ASSERT_IMPL(a_scan_ascends, i_clk, i_rst_n, r_rd_vld && r_rd_data, r_rd_addr > r_prev)
    `ASSERT_IMPL(a_rem_below_half, i_clk, i_rst_n, r_div_act, r_rem < half)
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !r_out_vld || !i_out_stall)
    `ASSERT_NEXT(a_miss_is_zero, i_clk, i_rst_n, i_cmd.out_load && !i_cmd.res_found,
                 r_out_pick == '0)

endmodule

[sv/largest_gap_channel_bisector_unit.sv]
// top level of the largest gap channel bisector
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall   | opcode, mark, bounds, random
//  out     | output    | o_out_valid / i_out_stall | found, picked_channel
//
// one request at a time; each request gives one result
// clear writes one map bit per cycle, mark writes a single map bit
// bisect reads one map bit per cycle in the scan,
// then runs a bit-serial remainder when the gap is wide
// after reset the whole map is cleared with o_in_stall high
// a finished result waits in the output register; the next request is taken meanwhile
module largest_gap_channel_bisector_unit
    import lgcb_pkg::*;
#(
    parameter int NUM_CHANNELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_opcode,
    input  logic [CH_PORT_W-1:0] i_mark_channel,
    input  logic [CH_PORT_W-1:0] i_lower_bound,
    input  logic [CH_PORT_W-1:0] i_upper_bound,
    input  logic [RND_W-1:0]     i_random_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic [CH_PORT_W-1:0] o_picked_channel
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    lgcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // map and arithmetic
    lgcb_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mark_channel   (i_mark_channel),
        .i_lower_bound    (i_lower_bound),
        .i_upper_bound    (i_upper_bound),
        .i_random_value   (i_random_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_picked_channel (o_picked_channel)
    );

endmodule

[verif/largest_gap_channel_bisector_unit_tb.sv]
// testbench for the largest gap channel bisector: directed and random requests, self-checking
module largest_gap_channel_bisector_unit_tb;
    import lgcb_pkg::*;

    localparam int NUM_CH      = 256;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE_CYC  = 400;
    localparam int RAND_TARGET = 400;

    // opcode with no function in the block
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [1:0]           op;
        logic [CH_PORT_W-1:0] mark;
        logic [CH_PORT_W-1:0] lo;
        logic [CH_PORT_W-1:0] hi;
        logic [RND_W-1:0]     rnd;
    } t_req;

    typedef struct {
        logic                 found;
        logic [CH_PORT_W-1:0] pick_ch;
    } t_resp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_opcode = OP_CLEAR;
    logic [CH_PORT_W-1:0] i_mark_channel = '0;
    logic [CH_PORT_W-1:0] i_lower_bound = '0;
    logic [CH_PORT_W-1:0] i_upper_bound = '0;
    logic [RND_W-1:0]     i_random_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_found;
    logic [CH_PORT_W-1:0] o_picked_channel;

    // probed channel map as the block should hold it
    bit [NUM_CH:0] probed_map = '0;

    t_req  pending_reqs[$];
    t_resp expected_picks[$];

    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_clear    = 0;
    int n_mark     = 0;
    int n_bisect   = 0;
    int n_found    = 0;
    int n_counted  = 0;
    int cycle_cnt  = 0;
    int gap_left   = 0;
    int burst_left = 1;
    int stall_left = 0;
    int free_left  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    largest_gap_channel_bisector_unit #(
        .NUM_CHANNELS(NUM_CH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_mark_channel  (i_mark_channel),
        .i_lower_bound   (i_lower_bound),
        .i_upper_bound   (i_upper_bound),
        .i_random_value  (i_random_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_picked_channel(o_picked_channel)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // map update and expected answer for one accepted request
    function automatic void predict_pick(input t_req rq, output t_resp rs);
        int lo, hi, best, start, stop, prev, gap, half, quart, pick;
        rs.found   = 1'b0;
        rs.pick_ch = '0;
        case (rq.op)
            OP_CLEAR: begin
                probed_map = '0;
                n_clear++;
            end
            OP_MARK: begin
                if (rq.mark <= NUM_CH) begin
                    probed_map[rq.mark] = 1'b1;
                    n_mark++;
                end
            end
            OP_BISECT: begin
                n_bisect++;
                lo = (rq.lo > NUM_CH) ? NUM_CH : int'(rq.lo);
                hi = (rq.hi > NUM_CH) ? NUM_CH : int'(rq.hi);
                probed_map[lo] = 1'b1;
                probed_map[hi] = 1'b1;
                best  = 0;
                start = lo;
                stop  = hi;
                prev  = lo;
                // widest unmarked run, first one wins a tie
                for (int j = lo + 1; j <= hi; j++) begin
                    if (probed_map[j]) begin
                        gap = j - prev - 1;
                        if (gap > best) begin
                            best  = gap;
                            start = prev;
                            stop  = j;
                        end
                        prev = j;
                    end
                end
                if (best > GAP_MIN) begin
                    if (best > GAP_WIDE) begin
                        half  = best >> 1;
                        quart = half >> 1;
                        pick  = start + (int'(rq.rnd) % half) + quart;
                    end else begin
                        pick = (start + stop) >> 1;
                    end
                    if (pick > NUM_CH) pick = NUM_CH;
                    probed_map[pick] = 1'b1;
                    rs.found   = 1'b1;
                    rs.pick_ch = pick[CH_PORT_W-1:0];
                    n_found++;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic add_req(input logic [1:0] op, input int mark, input int lo, input int hi,
                           input int rnd);
        t_req rq;
        rq.op   = op;
        rq.mark = mark[CH_PORT_W-1:0];
        rq.lo   = lo[CH_PORT_W-1:0];
        rq.hi   = hi[CH_PORT_W-1:0];
        rq.rnd  = rnd[RND_W-1:0];
        pending_reqs.push_back(rq);
        if (op == OP_CLEAR || op == OP_BISECT || (op == OP_MARK && mark <= NUM_CH))
            n_counted++;
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin : driver
        t_req  acc;
        t_resp rs;
        int    r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                acc = pending_reqs.pop_front();
                predict_pick(acc, rs);
                expected_picks.push_back(rs);
                n_accepted++;
            end
            // a stalled request holds its payload
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_in_valid     <= 1'b1;
                    i_opcode       <= pending_reqs[0].op;
                    i_mark_channel <= pending_reqs[0].mark;
                    i_lower_bound  <= pending_reqs[0].lo;
                    i_upper_bound  <= pending_reqs[0].hi;
                    i_random_value <= pending_reqs[0].rnd;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 8);
                        r = $urandom_range(0, 7);
                        if (r < 2) gap_left = 0;
                        else if (r < 6) gap_left = $urandom_range(1, 16);
                        else gap_left = $urandom_range(17, 200);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern, with one long hold-off to back the block up
    always @(posedge i_clk) begin : receiver
        int r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_done && n_accepted >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (free_left != 0) begin
                free_left--;
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 5) stall_left = $urandom_range(1, 10);
                else if (r < 7) stall_left = $urandom_range(11, 200);
                else stall_left = 0;
                free_left = (r == 9) ? $urandom_range(500, 1500) : $urandom_range(1, 60);
                i_out_stall <= (stall_left != 0);
                if (stall_left != 0) stall_left--;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : monitor
        t_resp exp_rs;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_picks.size() == 0) begin
                $error("unexpected result: found %0d picked_channel %0d",
                       o_found, o_picked_channel);
                n_errors++;
            end else begin
                exp_rs = expected_picks.pop_front();
                if (o_found !== exp_rs.found) begin
                    $error("found mismatch: expected %0d, actual %0d", exp_rs.found, o_found);
                    n_errors++;
                end
                if (o_picked_channel !== exp_rs.pick_ch) begin
                    $error("picked_channel mismatch: expected %0d, actual %0d",
                           exp_rs.pick_ch, o_picked_channel);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int lo, hi, len, r, nb;

        // empty map, full window, both ends of the random value
        add_req(OP_BISECT, 0, 0, NUM_CH, 0);
        add_req(OP_BISECT, 511, 0, NUM_CH, 32767);
        // marks at the map ends and beyond them
        add_req(OP_MARK, NUM_CH, 0, 0, 0);
        add_req(OP_MARK, 0, 511, 511, 32767);
        add_req(OP_MARK, 511, 0, 0, 0);
        add_req(OP_MARK, NUM_CH + 1, 0, 0, 0);
        add_req(OP_CLEAR, 511, 511, 511, 32767);
        // bounds beyond the map saturate
        add_req(OP_BISECT, 0, 300, 511, 12345);
        // inverted window
        add_req(OP_BISECT, 0, 100, 50, 0);
        add_req(OP_CLEAR, 0, 0, 0, 0);
        // narrow gap, gaps of two and four, first wide gap
        add_req(OP_BISECT, 0, 10, 12, 0);
        add_req(OP_BISECT, 0, 20, 23, 0);
        add_req(OP_BISECT, 0, 30, 35, 0);
        add_req(OP_BISECT, 0, 40, 46, 1);
        // equal gaps, the lower one wins
        add_req(OP_CLEAR, 0, 0, 0, 0);
        add_req(OP_MARK, 5, 0, 0, 0);
        add_req(OP_BISECT, 0, 0, 10, 0);
        // single-channel windows at both ends
        add_req(OP_BISECT, 0, NUM_CH, NUM_CH, 0);
        add_req(OP_BISECT, 0, 0, 0, 0);
        add_req(OP_BISECT, 0, 511, 511, 32767);
        // unused opcode with every field at its top, then at zero
        add_req(OP_NONE, 511, 511, 511, 32767);
        add_req(OP_NONE, 0, 0, 0, 0);
        n_counted = 0;

        // random episodes: maybe clear, up to three marks, maybe an unused opcode, then repeated bisects of one window
        while (n_counted < RAND_TARGET) begin
            r = $urandom_range(0, 9);
            if (r == 0) add_req(OP_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511),
                                $urandom_range(0, 511), $urandom_range(0, 32767));
            len = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
                add_req(OP_MARK, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                             : $urandom_range(0, NUM_CH),
                        $urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 32767));
            end
            if ($urandom_range(0, 9) == 0)
                add_req(OP_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 511), $urandom_range(0, 32767));
            r = $urandom_range(0, 9);
            if (r < 6) begin
                lo = $urandom_range(0, NUM_CH - 2);
                hi = lo + $urandom_range(2, 40);
            end else if (r < 8) begin
                lo = $urandom_range(0, 20);
                hi = $urandom_range(200, NUM_CH);
            end else if (r == 8) begin
                lo = $urandom_range(0, 511);
                hi = $urandom_range(0, 511);
            end else begin
                lo = $urandom_range(0, NUM_CH);
                hi = $urandom_range(0, lo);
            end
            nb = $urandom_range(1, 6);
            for (int k = 0; k < nb; k++) begin
                add_req(OP_BISECT, $urandom_range(0, 511), lo, hi, $urandom_range(0, 32767));
            end
        end

        // single reset at start of run
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (expected_picks.size() != 0) n_errors++;

        $display("requests %0d, results %0d: %0d clears, %0d marks, %0d bisects",
                 n_accepted, n_results, n_clear, n_mark, n_bisect);
        $display("bisects that picked a channel %0d, mismatches %0d", n_found, n_errors);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
